// ===== hw/rtl/vcrle_pkg.sv =====
// Shared types and constants of the voxel cell run-length encoder.
`timescale 1ns / 1ps
package vcrle_pkg;

  // Saturation limit of the cell and run counters.
  localparam logic [30:0] CountMax = 31'h7FFF_FFFF;

  // Depth of the queue between front and back; a power of two.
  localparam int unsigned QueueDepth = 4;

  // Register index decoded from paddr bit 2.
  localparam logic RegExpectedCells = 1'b0;

  // One voxel cell, filled byte on top as it is packed for comparison.
  typedef struct packed {
    logic [7:0] filled;
    logic [7:0] material;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } cell_t;

  // Input word: a cell and its end-of-map mark.
  typedef struct packed {
    logic [7:0] filled;
    logic [7:0] material;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       end_of_map;
  } cell_word_t;

  // Output word: one run.
  typedef struct packed {
    logic [31:0] run_length;
    logic [7:0]  run_filled;
    logic [7:0]  run_material;
    logic [7:0]  run_red;
    logic [7:0]  run_green;
    logic [7:0]  run_blue;
    logic [7:0]  run_alpha;
    logic        last_run;
    logic [30:0] total_runs;
    logic        size_error;
  } run_word_t;

  // A run as it travels through the queue.
  typedef struct packed {
    logic [31:0] length;
    cell_t       voxel;
  } run_t;

  // Everything one cell causes: an optional closed run and an optional final run.
  typedef struct packed {
    logic        has_a;
    run_t        run_a;
    logic        has_b;
    run_t        run_b;
    logic [30:0] total;
    logic        err;
  } rec_t;

endpackage

// ===== hw/rtl/vcrle_if.sv =====
// Valid/ready channel interfaces for cell words and run words.
`timescale 1ns / 1ps
interface vcrle_cell_if;
  import vcrle_pkg::*;
  logic       valid;
  logic       ready;
  cell_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vcrle_run_if;
  import vcrle_pkg::*;
  logic      valid;
  logic      ready;
  run_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/voxel_cell_run_length_encoder_core.sv =====
// Top level of the voxel cell run-length encoder with its register port.
//
//   channel   dir  handshake      word
//   cell_i    in   valid/ready    six cell bytes and end_of_map
//   run_o     out  valid/ready    run length, run bytes, last_run, totals
//   apb       in   psel/penable   expected_cells at byte address 0
//
// One cell is accepted per cycle while the queue has room; each run passes the queue and
// the back's record register. A cell that closes a run and ends the map gives two words.
// A four-record queue lets input and output stall on their own; cell_i.ready drops
// only when it is full. Reset clears the held run, the counters and the queue,
// and sets expected_cells to 1.
`timescale 1ns / 1ps
module voxel_cell_run_length_encoder_core #(
  parameter int unsigned RunLengthBits = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vcrle_cell_if.sink  cell_i,
  vcrle_run_if.source run_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vcrle_pkg::*;

  logic [30:0] expected_q;
  logic        cfg_write;
  logic        push;
  logic        pop;
  logic        full;
  logic        empty;
  rec_t        rec_in;
  rec_t        rec_out;

  // Register port: always ready, one register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == RegExpectedCells);
  assign prdata    = (paddr[2] == RegExpectedCells) ? {1'b0, expected_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q <= 31'd1;
    end else if (cfg_write) begin
      expected_q <= pwdata[30:0];
    end
  end

  vcrle_front #(
    .RunLengthBits (RunLengthBits)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cell_i           (cell_i),
    .expected_cells_i (expected_q),
    .full_i           (full),
    .push_o           (push),
    .rec_o            (rec_in)
  );

  vcrle_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (rec_in),
    .pop_i   (pop),
    .rdata_o (rec_out),
    .full_o  (full),
    .empty_o (empty)
  );

  vcrle_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rec_i   (rec_out),
    .empty_i (empty),
    .pop_o   (pop),
    .run_o   (run_o)
  );

endmodule

// ===== hw/rtl/vcrle_front.sv =====
// Front part: accepts cells, tracks the held run and counters, builds queue records.
`timescale 1ns / 1ps
module vcrle_front #(
  parameter int unsigned RunLengthBits = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  vcrle_cell_if.sink       cell_i,
  input  logic [30:0]      expected_cells_i,
  input  logic             full_i,
  output logic             push_o,
  output vcrle_pkg::rec_t  rec_o
);
  import vcrle_pkg::*;

  localparam logic [RunLengthBits-1:0] LenMax = '1;
  localparam logic [RunLengthBits-1:0] LenOne = RunLengthBits'(1);

  cell_t                    held_cell_q, held_cell_d;
  logic [RunLengthBits-1:0] held_len_q, held_len_d;
  logic [30:0]              cells_q, cells_d;
  logic [30:0]              runs_q, runs_d;
  logic                     over_q, over_d;

  cell_t                    cell_in;
  logic                     accept;
  logic                     extend;
  logic                     close_a;
  logic [RunLengthBits-1:0] len_new;
  cell_t                    cell_new;
  logic [30:0]              cells_inc;
  logic [30:0]              runs_a;
  logic [30:0]              runs_b;
  logic                     over_new;

  assign cell_i.ready = !full_i;
  assign accept       = cell_i.valid && cell_i.ready;

  assign cell_in = '{filled: cell_i.data.filled, material: cell_i.data.material,
                     red: cell_i.data.red, green: cell_i.data.green,
                     blue: cell_i.data.blue, alpha: cell_i.data.alpha};

  // Cell counter saturates; a cell past the limit sets the sticky over-count bit.
  assign cells_inc = (cells_q == CountMax) ? cells_q : cells_q + 31'd1;
  assign over_new  = over_q || (cells_q == CountMax);

  // Merge the cell into the held run, or close the held run and start a new one.
  assign extend   = (held_len_q != '0) && (cell_in == held_cell_q) && (held_len_q != LenMax);
  assign close_a  = (held_len_q != '0) && !extend;
  assign len_new  = extend ? held_len_q + LenOne : LenOne;
  assign cell_new = extend ? held_cell_q : cell_in;

  // Run counter: one count for a closed run, one more for the final run.
  assign runs_a = (close_a && (runs_q != CountMax)) ? runs_q + 31'd1 : runs_q;
  assign runs_b = (runs_a != CountMax) ? runs_a + 31'd1 : runs_a;

  // Queue record for this cell.
  always_comb begin
    rec_o.has_a         = close_a;
    rec_o.run_a.length  = 32'(held_len_q);
    rec_o.run_a.voxel   = held_cell_q;
    rec_o.has_b         = cell_i.data.end_of_map;
    rec_o.run_b.length  = 32'(len_new);
    rec_o.run_b.voxel   = cell_new;
    rec_o.total         = runs_b;
    rec_o.err           = over_new || (cells_inc != expected_cells_i);
  end

  assign push_o = accept && (close_a || cell_i.data.end_of_map);

  // Next state; the end mark returns everything to the empty map.
  always_comb begin
    held_cell_d = held_cell_q;
    held_len_d  = held_len_q;
    cells_d     = cells_q;
    runs_d      = runs_q;
    over_d      = over_q;
    if (accept) begin
      if (cell_i.data.end_of_map) begin
        held_cell_d = '0;
        held_len_d  = '0;
        cells_d     = '0;
        runs_d      = '0;
        over_d      = 1'b0;
      end else begin
        held_cell_d = cell_new;
        held_len_d  = len_new;
        cells_d     = cells_inc;
        runs_d      = runs_a;
        over_d      = over_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cell_q <= '0;
      held_len_q  <= '0;
      cells_q     <= '0;
      runs_q      <= '0;
      over_q      <= 1'b0;
    end else begin
      held_cell_q <= held_cell_d;
      held_len_q  <= held_len_d;
      cells_q     <= cells_d;
      runs_q      <= runs_d;
      over_q      <= over_d;
    end
  end

`ifndef SYNTHESIS
  // A cell with the end mark leaves no run held.
  a_eom_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cell_i.data.end_of_map |=> held_len_q == '0)
    else $error("held run survived the end of the map");

  // A cell without the end mark always leaves a run held.
  a_run_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !cell_i.data.end_of_map |=> held_len_q != '0)
    else $error("no run held after a cell");
`endif

endmodule

// ===== hw/rtl/vcrle_fifo.sv =====
// Short queue of run records between the front and the back.
`timescale 1ns / 1ps
module vcrle_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  vcrle_pkg::rec_t wdata_i,
  input  logic            pop_i,
  output vcrle_pkg::rec_t rdata_o,
  output logic            full_o,
  output logic            empty_o
);
  import vcrle_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  rec_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Storage needs no reset; only occupied entries are read.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  // The back never takes a record that is not there.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from an empty queue");

  // A record pushed without a pop is visible in the next cycle.
  a_push_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> !empty_o)
    else $error("pushed record lost");
`endif

endmodule

// ===== hw/rtl/vcrle_back.sv =====
// Back part: takes records from the queue and sends their runs one word at a time.
`timescale 1ns / 1ps
module vcrle_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  vcrle_pkg::rec_t rec_i,
  input  logic            empty_i,
  output logic            pop_o,
  vcrle_run_if.source     run_o
);
  import vcrle_pkg::*;

  rec_t rec_q, rec_d;
  logic a_pend_q, a_pend_d;
  logic b_pend_q, b_pend_d;
  logic busy;
  logic sent;
  logic done;

  assign busy = a_pend_q || b_pend_q;
  assign sent = run_o.valid && run_o.ready;
  // The held record is finished when its only remaining word goes out.
  assign done = sent && !(a_pend_q && b_pend_q);
  assign pop_o = !empty_i && (!busy || done);

  // Load a new record or retire the word just sent.
  always_comb begin
    rec_d    = rec_q;
    a_pend_d = a_pend_q;
    b_pend_d = b_pend_q;
    if (pop_o) begin
      rec_d    = rec_i;
      a_pend_d = rec_i.has_a;
      b_pend_d = rec_i.has_b;
    end else if (sent) begin
      if (a_pend_q) begin
        a_pend_d = 1'b0;
      end else begin
        b_pend_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_pend_q <= 1'b0;
      b_pend_q <= 1'b0;
    end else begin
      a_pend_q <= a_pend_d;
      b_pend_q <= b_pend_d;
    end
  end

  // The closed run goes first; the final run carries the map totals.
  always_comb begin
    run_o.valid = busy;
    if (a_pend_q) begin
      run_o.data.run_length   = rec_q.run_a.length;
      run_o.data.run_filled   = rec_q.run_a.voxel.filled;
      run_o.data.run_material = rec_q.run_a.voxel.material;
      run_o.data.run_red      = rec_q.run_a.voxel.red;
      run_o.data.run_green    = rec_q.run_a.voxel.green;
      run_o.data.run_blue     = rec_q.run_a.voxel.blue;
      run_o.data.run_alpha    = rec_q.run_a.voxel.alpha;
      run_o.data.last_run     = 1'b0;
      run_o.data.total_runs   = '0;
      run_o.data.size_error   = 1'b0;
    end else begin
      run_o.data.run_length   = rec_q.run_b.length;
      run_o.data.run_filled   = rec_q.run_b.voxel.filled;
      run_o.data.run_material = rec_q.run_b.voxel.material;
      run_o.data.run_red      = rec_q.run_b.voxel.red;
      run_o.data.run_green    = rec_q.run_b.voxel.green;
      run_o.data.run_blue     = rec_q.run_b.voxel.blue;
      run_o.data.run_alpha    = rec_q.run_b.voxel.alpha;
      run_o.data.last_run     = 1'b1;
      run_o.data.total_runs   = rec_q.total;
      run_o.data.size_error   = rec_q.err;
    end
  end

`ifndef SYNTHESIS
  // A record of two runs sends the closed run and keeps the final run pending.
  a_two_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sent && a_pend_q && b_pend_q |=> !a_pend_q && b_pend_q)
    else $error("final run dropped after closed run");
`endif

endmodule
